/* rtl/core/xfsd_pkg.sv */
// Shared constants, types and decode helpers for the status frame decoder.
`default_nettype none
package xfsd_pkg;

  localparam int FRAME_BYTES = 21;
  localparam int POS_W       = 5;

  localparam logic [POS_W-1:0] POS_IDLE   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_MODE   = POS_W'(7);
  localparam logic [POS_W-1:0] POS_FAN    = POS_W'(8);
  localparam logic [POS_W-1:0] POS_SENSOR = POS_W'(17);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);

  localparam logic [7:0] START_BYTE  = 8'hBB;
  localparam logic [7:0] TYPE_STATUS = 8'h01;
  localparam logic [3:0] HI_OFF      = 4'h2;

  localparam logic [4:0]  TARGET_BASE = 5'd16;
  localparam logic [13:0] ROOM_OFFSET = 14'd1133;
  // floor(x/3) == (x*171) >> 9 for every 8-bit x
  localparam logic [7:0]  THIRD_MUL   = 8'd171;
  localparam int          THIRD_SHIFT = 9;

  typedef enum logic [2:0] {
    MODE_OFF  = 3'd0,
    MODE_COOL = 3'd1,
    MODE_FAN  = 3'd2,
    MODE_DRY  = 3'd3,
    MODE_HEAT = 3'd4,
    MODE_AUTO = 3'd5
  } mode_t;

  function automatic mode_t decode_mode(input logic [7:0] b);
    mode_t m;
    if (b[3:0] == 4'h0 || b[7:4] == HI_OFF) begin
      m = MODE_OFF;
    end else begin
      case (b[3:0])
        4'h1: m = MODE_COOL;
        4'h2: m = MODE_FAN;
        4'h3: m = MODE_DRY;
        4'h4: m = MODE_HEAT;
        4'h5: m = MODE_AUTO;
        default: m = MODE_COOL;
      endcase
    end
    return m;
  endfunction

  function automatic logic [1:0] decode_fan(input logic [7:0] b);
    logic [1:0] f;
    if (b[7:6] == 2'b00) begin
      f = b[5:4];
    end else begin
      f = 2'd0;
    end
    return f;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/xor_frame_status_decoder_top.sv */
// Status frame receiver: start-byte hunt, XOR check and field decode.
`default_nettype none
// Takes one received byte per beat on the rx channel and gives one status beat for
// every valid 21-byte frame (start byte 0xBB, type byte 0x01, XOR of the first 20
// bytes equal to the last byte); bad frames are dropped without notice. The frame
// position counter and running XOR update at the edge that accepts each byte, and
// the decoded status is formed in the same cycle into a single output register, so
// a byte can be accepted every cycle while rx_stall is low. rx_stall rises only
// while a status beat is held in that register and status_stall is high.
module xor_frame_status_decoder_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         rx_valid,
  output logic        rx_stall,
  input  wire  [7:0]  rx_byte,
  output logic        status_valid,
  input  wire         status_stall,
  output logic [2:0]  unit_mode,
  output logic [1:0]  fan_speed,
  output logic [4:0]  target_celsius,
  output logic signed [13:0] room_centi_celsius
);

  logic [xfsd_pkg::POS_W-1:0] pos;
  logic [xfsd_pkg::POS_W-1:0] pos_next;
  logic [7:0] running_xor;
  logic [7:0] running_xor_next;
  logic [7:0] type_byte;
  logic [7:0] mode_byte;
  logic [7:0] fan_temp_byte;
  logic [7:0] sensor_byte;

  logic        rx_fire;
  logic        at_last;
  logic        frame_ok;
  logic [4:0]  target;
  logic [15:0] third_prod;
  logic [13:0] scaled;
  logic [13:0] room_bits;

  assign rx_stall = status_valid && status_stall;
  assign rx_fire  = rx_valid && !rx_stall;
  assign at_last  = (pos >= xfsd_pkg::POS_LAST);
  assign frame_ok = at_last && (type_byte == xfsd_pkg::TYPE_STATUS)
                    && (running_xor == rx_byte);

  always_comb begin
    pos_next         = pos;
    running_xor_next = running_xor;
    if (pos == xfsd_pkg::POS_IDLE) begin
      if (rx_byte == xfsd_pkg::START_BYTE) begin
        pos_next         = xfsd_pkg::POS_TYPE;
        running_xor_next = rx_byte;
      end
    end else if (at_last) begin
      pos_next = xfsd_pkg::POS_IDLE;
    end else begin
      pos_next         = pos + xfsd_pkg::POS_W'(1);
      running_xor_next = running_xor ^ rx_byte;
    end
  end

  // room = 33*raw + floor(raw/3) - 1133, or target*100 when the sensor byte is zero
  assign target     = {1'b0, fan_temp_byte[3:0]} + xfsd_pkg::TARGET_BASE;
  assign third_prod = 16'(sensor_byte) * 16'(xfsd_pkg::THIRD_MUL);
  assign scaled     = (14'(sensor_byte) << 5) + 14'(sensor_byte)
                      + 14'(third_prod >> xfsd_pkg::THIRD_SHIFT);

  always_comb begin
    if (sensor_byte != 8'd0) begin
      room_bits = scaled - xfsd_pkg::ROOM_OFFSET;
    end else begin
      room_bits = (14'(target) << 6) + (14'(target) << 5) + (14'(target) << 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= xfsd_pkg::POS_IDLE;
      running_xor <= 8'd0;
    end else if (rx_fire) begin
      pos         <= pos_next;
      running_xor <= running_xor_next;
    end
  end

  // Capture the fields needed for the decode.
  always_ff @(posedge clk) begin
    if (rst) begin
      type_byte     <= 8'd0;
      mode_byte     <= 8'd0;
      fan_temp_byte <= 8'd0;
      sensor_byte   <= 8'd0;
    end else if (rx_fire) begin
      case (pos)
        xfsd_pkg::POS_TYPE:   type_byte     <= rx_byte;
        xfsd_pkg::POS_MODE:   mode_byte     <= rx_byte;
        xfsd_pkg::POS_FAN:    fan_temp_byte <= rx_byte;
        xfsd_pkg::POS_SENSOR: sensor_byte   <= rx_byte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (rx_fire && frame_ok) begin
      status_valid <= 1'b1;
    end else if (!status_stall) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire && frame_ok) begin
      unit_mode          <= xfsd_pkg::decode_mode(mode_byte);
      fan_speed          <= xfsd_pkg::decode_fan(fan_temp_byte);
      target_celsius     <= target;
      room_centi_celsius <= $signed(room_bits);
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= xfsd_pkg::POS_LAST)
    else $error("frame position beyond last byte");

  a_start_hunt: assert property (@(posedge clk) disable iff (rst)
    rx_fire && pos == xfsd_pkg::POS_IDLE && rx_byte == xfsd_pkg::START_BYTE
    |=> pos == xfsd_pkg::POS_TYPE && running_xor == xfsd_pkg::START_BYTE)
    else $error("start byte did not open a frame");

  a_beat_source: assert property (@(posedge clk) disable iff (rst)
    $rose(status_valid) |-> $past(rx_fire && at_last && frame_ok))
    else $error("status beat without a checked last byte");

  a_room_range: assert property (@(posedge clk) disable iff (rst)
    status_valid |-> room_centi_celsius >= -14'sd1133 && room_centi_celsius <= 14'sd7367)
    else $error("room temperature out of range");
`endif

endmodule
`default_nettype wire
